// ----- design/klex_pkg.sv -----
// Package for the k-subset lexicographic enumerator.
// Holds widths, register index codes and the cell control struct.
// No dependencies.
`default_nettype none

package klex_pkg;

  localparam int NUM_CELLS = 16;              // largest subset size k
  localparam int MAX_STATES = 64;             // largest state count n
  localparam int IDX_W = 6;                   // one state index
  localparam int CELL_W = 4;                  // position of a cell in the row
  localparam int N_W = 7;                     // num_states register
  localparam int K_W = 5;                     // num_particles register
  localparam int OCC_W = 64;                  // occupancy mask
  localparam int ORD_W = 64;                  // ordinal counter
  localparam int CFG_W = 7;                   // widest register
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PARTICLES = 1'b1;

  localparam logic [N_W-1:0] N_LIMIT = N_W'(MAX_STATES);
  localparam logic [K_W-1:0] K_LIMIT = K_W'(NUM_CELLS);

  // Control that the sequencer broadcasts to every cell.
  typedef struct packed {
    logic             load_first;  // restart: load index i into cell i
    logic             advance;     // commit one odometer step
    logic [K_W-1:0]   k;
    logic [IDX_W-1:0] span;        // n - k
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/klex_cell.sv -----
// One odometer cell: holds one index of the sorted subset.
// Passes the pivot search leftward and the refill base and mask rightward.
// Depends on klex_pkg.
`default_nettype none

module klex_cell (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire  [klex_pkg::CELL_W-1:0]    cell_idx,
  input  klex_pkg::cell_ctl_t            ctl,
  input  wire                            found_in,
  input  wire                            aft_in,
  input  wire  [klex_pkg::IDX_W-1:0]     base_in,
  input  wire  [klex_pkg::IDX_W-1:0]     base_sel,
  input  wire  [klex_pkg::OCC_W-1:0]     occ_in,
  output logic                           found_out,
  output logic                           aft_out,
  output logic [klex_pkg::IDX_W-1:0]     base_out,
  output logic [klex_pkg::OCC_W-1:0]     occ_out,
  output logic [klex_pkg::IDX_W-1:0]     idx_o
);
  import klex_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] pos6;
  logic             active, below, cand, pivot;
  logic [N_W-1:0]   limit;
  logic [OCC_W-1:0] onehot;

  assign pos6   = IDX_W'(cell_idx);
  assign active = K_W'(cell_idx) < ctl.k;
  assign limit  = N_W'(ctl.span) + N_W'(cell_idx);
  assign below  = N_W'(idx_r) < limit;
  assign cand   = active & below;
  // pivot: rightmost candidate, none to the right
  assign pivot     = cand & ~found_in;
  assign found_out = cand | found_in;
  assign aft_out   = aft_in | pivot;
  // pivot hands out (value - position + 1); every refilled cell adds its position
  assign base_out  = base_in | (pivot ? (idx_r - pos6 + IDX_W'(1)) : '0);

  always_comb begin
    onehot = '0;
    onehot[idx_r] = active;
  end
  assign occ_out = occ_in | onehot;
  assign idx_o   = idx_r;

  always_comb begin
    idx_nxt = idx_r;
    if (ctl.load_first && active) begin
      idx_nxt = pos6;
    end else if (ctl.advance && active && (aft_in || pivot)) begin
      idx_nxt = base_sel + pos6;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/k_subset_lexicographic_enumerator_unit.sv -----
// Top level of the k-subset lexicographic enumerator.
// Sequencer, configuration registers, ordinal counter and a row of klex_cell.
// Depends on klex_pkg and klex_cell.
//
// Usage:
//   Input channel (in_valid/in_ready/in_restart): each item is a restart
//   (in_restart = 1, load subset {0..k-1}) or an advance (next subset in
//   lexicographic order). Every item yields exactly one result item.
//   Result channel (out_valid/out_ready): occupancy mask, ordinal, is_final,
//   exhausted and config_error. config_error wins over everything; exhausted
//   flags an advance after the final subset (mask and ordinal then zero).
//   Configuration: cfg_we writes cfg_wdata into num_states (index 0) or
//   num_particles (index 1) at once; write only while the block is idle.
// Sequence:
//   The CALC state runs the pivot search and refill across the cell row, and
//   the EMIT state loads the output register from the updated row. A new
//   item is taken in the IDLE or EMIT state, so the block accepts no new
//   item while the search for the last one runs.
// Reset (rst_n, synchronous, active low): n = 8, k = 4, all indices zero,
//   ordinal zero, and the enumeration counts as finished until a restart.
// Stall: while out_ready is low the finished result holds in the output
//   register; one further item may complete its search and then waits, and
//   in_ready stays low until the output register frees.
`default_nettype none

module k_subset_lexicographic_enumerator_unit (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire                            in_restart,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [klex_pkg::OCC_W-1:0]     out_occupancy,
  output logic [klex_pkg::ORD_W-1:0]     out_ordinal,
  output logic                           out_is_final,
  output logic                           out_exhausted,
  output logic                           out_config_error,
  input  wire                            cfg_we,
  input  wire  [klex_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [klex_pkg::CFG_W-1:0]     cfg_wdata
);
  import klex_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [N_W-1:0]   num_states_r, num_states_nxt;
  logic [K_W-1:0]   num_particles_r, num_particles_nxt;
  logic             restart_r, restart_nxt;
  logic             done_r, done_nxt;
  logic [ORD_W-1:0] pos_r, pos_nxt;
  logic             exh_r, exh_nxt;
  logic             err_r, err_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [ORD_W-1:0] ord_r, ord_nxt;
  logic             fin_r, fin_nxt;
  logic             oexh_r, oexh_nxt;
  logic             oerr_r, oerr_nxt;

  logic             in_fire, slot_free, load_out;
  logic             cfg_err, found, fin_now;
  logic [N_W-1:0]   span_w;
  cell_ctl_t        ctl;

  // cell row links
  logic [NUM_CELLS:0]            found_chain;
  logic [NUM_CELLS:0]            aft_chain;
  logic [NUM_CELLS:0][IDX_W-1:0] base_chain;
  logic [NUM_CELLS:0][OCC_W-1:0] occ_chain;
  logic [NUM_CELLS-1:0][IDX_W-1:0] idx_w;

  // bad configuration: k zero, k above n, n above MAX_STATES, or k beyond the row's size
  assign cfg_err = (num_particles_r == '0) || (N_W'(num_particles_r) > num_states_r) ||
                   (num_states_r > N_LIMIT) || (num_particles_r > K_LIMIT);
  assign span_w  = num_states_r - N_W'(num_particles_r);

  assign slot_free = ~out_valid_r | out_ready;
  assign in_ready  = (state_r == ST_IDLE) || ((state_r == ST_EMIT) && slot_free);
  assign in_fire   = in_valid & in_ready;
  assign load_out  = (state_r == ST_EMIT) && slot_free;

  assign found   = found_chain[0];
  assign fin_now = (idx_w[0] == span_w[IDX_W-1:0]);

  // Cells act only in the search cycle; restart wins, advance needs a live pivot.
  always_comb begin
    ctl.k          = num_particles_r;
    ctl.span       = span_w[IDX_W-1:0];
    ctl.load_first = (state_r == ST_CALC) && !cfg_err && restart_r;
    ctl.advance    = (state_r == ST_CALC) && !cfg_err && !restart_r && !done_r && found;
  end

  assign found_chain[NUM_CELLS] = 1'b0;
  assign aft_chain[0]  = 1'b0;
  assign base_chain[0] = '0;
  assign occ_chain[0]  = '0;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    klex_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (CELL_W'(g)),
      .ctl       (ctl),
      .found_in  (found_chain[g+1]),
      .aft_in    (aft_chain[g]),
      .base_in   (base_chain[g]),
      .base_sel  (base_chain[NUM_CELLS]),
      .occ_in    (occ_chain[g]),
      .found_out (found_chain[g]),
      .aft_out   (aft_chain[g+1]),
      .base_out  (base_chain[g+1]),
      .occ_out   (occ_chain[g+1]),
      .idx_o     (idx_w[g])
    );
  end

  // Configuration writes
  always_comb begin
    num_states_nxt    = num_states_r;
    num_particles_nxt = num_particles_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_STATES:    num_states_nxt    = cfg_wdata[N_W-1:0];
        CFG_NUM_PARTICLES: num_particles_nxt = cfg_wdata[K_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    restart_nxt = restart_r;
    done_nxt    = done_r;
    pos_nxt     = pos_r;
    exh_nxt     = exh_r;
    err_nxt     = err_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          restart_nxt = in_restart;
          state_nxt   = ST_CALC;
        end
      end
      ST_CALC: begin
        state_nxt = ST_EMIT;
        err_nxt   = 1'b0;
        exh_nxt   = 1'b0;
        priority if (cfg_err) begin
          done_nxt = 1'b1;
          err_nxt  = 1'b1;
        end else if (restart_r) begin
          pos_nxt = '0;
        end else if (done_r) begin
          exh_nxt = 1'b1;
        end else if (!found) begin
          done_nxt = 1'b1;
          exh_nxt  = 1'b1;
        end else begin
          pos_nxt = pos_r + ORD_W'(1);
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          // a real subset leaves the done flag at its final test
          if (!err_r && !exh_r) begin
            done_nxt = fin_now;
          end
          if (in_fire) begin
            restart_nxt = in_restart;
            state_nxt   = ST_CALC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register: load from the updated row, hold while stalled
  always_comb begin
    out_valid_nxt = out_valid_r;
    occ_nxt       = occ_r;
    ord_nxt       = ord_r;
    fin_nxt       = fin_r;
    oexh_nxt      = oexh_r;
    oerr_nxt      = oerr_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      occ_nxt       = (err_r || exh_r) ? '0 : occ_chain[NUM_CELLS];
      ord_nxt       = (err_r || exh_r) ? '0 : pos_r;
      fin_nxt       = !err_r && !exh_r && fin_now;
      oexh_nxt      = exh_r;
      oerr_nxt      = err_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      num_states_r    <= N_W'(8);
      num_particles_r <= K_W'(4);
      done_r          <= 1'b1;
      pos_r           <= '0;
      out_valid_r     <= 1'b0;
      restart_r       <= 1'b0;
      exh_r           <= 1'b0;
      err_r           <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      num_states_r    <= num_states_nxt;
      num_particles_r <= num_particles_nxt;
      done_r          <= done_nxt;
      pos_r           <= pos_nxt;
      out_valid_r     <= out_valid_nxt;
      restart_r       <= restart_nxt;
      exh_r           <= exh_nxt;
      err_r           <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    occ_r  <= occ_nxt;
    ord_r  <= ord_nxt;
    fin_r  <= fin_nxt;
    oexh_r <= oexh_nxt;
    oerr_r <= oerr_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_occupancy    = occ_r;
  assign out_ordinal      = ord_r;
  assign out_is_final     = fin_r;
  assign out_exhausted    = oexh_r;
  assign out_config_error = oerr_r;

endmodule

`default_nettype wire
